@@ src/kds_pkg.sv @@
// Package for the deposition/diffusion step core: item types, status codes,
// register indexes and default sizes.
// Depends on nothing; kmc_deposit_diffuse_step_core uses it by scoped names.
package kds_pkg;

  // Default lattice side and walker list capacity.
  localparam int unsigned SIDE_DEF       = 256;
  localparam int unsigned WALKER_CAP_DEF = 1024;

  // Field widths fixed by the item format.
  localparam int unsigned DRAW_W  = 14;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned PICK_W  = 31;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned RATE_W  = 32;

  // Deposition threshold scale.
  localparam logic [DRAW_W-1:0] DRAW_SCALE = 14'd10000;

  // Rate register reset value (1.0 in 16.16).
  localparam logic [RATE_W-1:0] RATE_ONE = 32'h0001_0000;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEP_RATE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_RATE = 1'b1;

  // Action codes.
  typedef enum logic [0:0] {
    ACT_DEPOSIT = 1'b0,
    ACT_DIFFUSE = 1'b1
  } action_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_OCCUPIED = 3'd1,
    ST_HOPPED   = 3'd2,
    ST_BLOCKED  = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  // Hop directions.
  typedef enum logic [1:0] {
    DIR_ROW_DN = 2'd0,
    DIR_COL_DN = 2'd1,
    DIR_COL_UP = 2'd2,
    DIR_ROW_UP = 2'd3
  } dir_e;

  // One input item.
  typedef struct packed {
    logic [DRAW_W-1:0]  draw;
    logic [COORD_W-1:0] site_row;
    logic [COORD_W-1:0] site_col;
    logic [PICK_W-1:0]  pick_raw;
    logic [1:0]         hop_dir;
  } in_item_t;

  // One result item.
  typedef struct packed {
    action_e            action;
    status_e            status;
    logic [COUNT_W-1:0] walker_count;
    logic [COORD_W-1:0] to_row;
    logic [COORD_W-1:0] to_col;
    logic [COORD_W-1:0] from_row;
    logic [COORD_W-1:0] from_col;
  } out_item_t;

endpackage

@@ src/kds_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; used for the lattice and the walker list.
module kds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write first in program order; a read of the same entry returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/kmc_deposit_diffuse_step_core.sv @@
// Top level of the submonolayer growth step core: control sequencer, rate test,
// walker pick and the lattice and walker list memories.
// Depends on kds_pkg and kds_ram.
//
// Usage: an item is taken on a rising edge with start high and busy low. The
// core then holds busy high until the result goes out: done_o is high for
// exactly one cycle with the result on result_o, and busy falls the cycle
// after. The receiver cannot hold a result off.
// Steps: rate products, a bit-serial loop that forms the deposition test
// products and the walker index (one remainder bit per cycle), a decision
// state, then lattice and list read-modify-write, plus a list search for
// each list removal (one entry compared per cycle).
// One item is in flight at a time.
// Reset: the lattice memory is swept to zero, one site per cycle, with busy
// high. Rate registers may be written meanwhile.
module kmc_deposit_diffuse_step_core #(
  parameter int unsigned SIDE       = kds_pkg::SIDE_DEF,
  parameter int unsigned WALKER_CAP = kds_pkg::WALKER_CAP_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  kds_pkg::in_item_t              item_i,
  output logic                           done_o,
  output kds_pkg::out_item_t             result_o,
  input  logic                           cfg_we_i,
  input  logic [kds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kds_pkg::RATE_W-1:0]     cfg_wdata_i
);

  localparam int unsigned CW     = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int unsigned SITES  = SIDE * SIDE;
  localparam int unsigned SAW    = $clog2(SITES);
  localparam int unsigned WAW    = $clog2(WALKER_CAP);
  localparam int unsigned WCW    = $clog2(WALKER_CAP + 1);
  localparam int unsigned SQW    = $clog2(SITES + 1);
  localparam int unsigned RDW    = kds_pkg::RATE_W + SQW;
  localparam int unsigned NDW    = kds_pkg::RATE_W + WCW;
  localparam int unsigned TW     = ((RDW > NDW) ? RDW : NDW) + 1;
  localparam int unsigned PW     = TW + kds_pkg::DRAW_W;
  localparam int unsigned LOOP_N = kds_pkg::PICK_W;
  localparam int unsigned CNT_W  = $clog2(LOOP_N);

  localparam logic [CW-1:0]  SIDE_M1 = CW'(SIDE - 1);
  localparam logic [SAW-1:0] CLR_END = SAW'(SITES - 1);
  localparam logic [WCW-1:0] CAP_N   = WCW'(WALKER_CAP);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(LOOP_N - 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CLEAR = 14'b00000000000010,
    S_MUL0  = 14'b00000000000100,
    S_MUL1  = 14'b00000000001000,
    S_LOOP  = 14'b00000000010000,
    S_DEC   = 14'b00000000100000,
    S_DRD   = 14'b00000001000000,
    S_WRD   = 14'b00000010000000,
    S_TRD   = 14'b00000100000000,
    S_SRC   = 14'b00001000000000,
    S_SRD   = 14'b00010000000000,
    S_SRCH  = 14'b00100000000000,
    S_MOVE  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_e;

  // Reduce an 8-bit coordinate modulo SIDE by restoring subtraction.
  function automatic logic [CW-1:0] side_mod(input logic [7:0] v);
    int unsigned t;
    t = 32'(v);
    for (int k = 7; k >= 0; k--) begin
      if (t >= (SIDE << k)) begin
        t = t - (SIDE << k);
      end
    end
    return CW'(t);
  endfunction

  function automatic logic [SAW-1:0] site_addr(input logic [CW-1:0] r,
                                                input logic [CW-1:0] c);
    return SAW'(r) * SAW'(SIDE) + SAW'(c);
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] x);
    return (x == 8'hFF) ? x : x + 8'd1;
  endfunction

  state_e state_q, state_d;
  logic [SAW-1:0]                 clr_q, clr_d;
  logic [WCW-1:0]                 n_q, n_d;
  logic [kds_pkg::RATE_W-1:0]     dep_q, diff_q;
  logic [kds_pkg::DRAW_W-1:0]     dsh_q, dsh_d, ksh_q, ksh_d;
  logic [CW-1:0]                  row_q, row_d, col_q, col_d;
  logic [kds_pkg::PICK_W-1:0]     pick_q, pick_d;
  logic [1:0]                     dir_q, dir_d;
  logic [NDW-1:0]                 prod_q, prod_d;
  logic [RDW-1:0]                 rdep_q, rdep_d;
  logic [PW-1:0]                  tsh_q, tsh_d, rsh_q, rsh_d, lacc_q, lacc_d, racc_q, racc_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [WCW-1:0]                 rem_q, rem_d;
  logic [CW-1:0]                  wr_q, wr_d, wc_q, wc_d, nr_q, nr_d, nc_q, nc_d;
  logic [2*CW-1:0]                key_q, key_d;
  logic                           ret_src_q, ret_src_d;
  logic [WCW-1:0]                 k_q, k_d;
  logic [WAW-1:0]                 chk_q, chk_d, j_q, j_d;
  logic                           hv_q, hv_d;
  kds_pkg::out_item_t             res_q, res_d;

  logic                           site_we;
  logic [SAW-1:0]                 site_waddr, site_raddr;
  logic [7:0]                     site_wdata, site_rdata;
  logic                           walk_we;
  logic [WAW-1:0]                 walk_waddr, walk_raddr;
  logic [2*CW-1:0]                walk_wdata, walk_rdata;

  logic [WCW:0]                   trial;
  logic [CW-1:0]                  hr, hc, hnr, hnc;
  logic                           hop_ok;
  logic                           key_hit;
  logic [WCW-1:0]                 n_m1;

  // Lattice counts and walker list memories.
  kds_ram #(.WIDTH(8), .DEPTH(SITES)) u_site_ram (
    .clk_i   (clk_i),
    .we_i    (site_we),
    .waddr_i (site_waddr),
    .wdata_i (site_wdata),
    .raddr_i (site_raddr),
    .rdata_o (site_rdata)
  );

  kds_ram #(.WIDTH(2 * CW), .DEPTH(WALKER_CAP)) u_walk_ram (
    .clk_i   (clk_i),
    .we_i    (walk_we),
    .waddr_i (walk_waddr),
    .wdata_i (walk_wdata),
    .raddr_i (walk_raddr),
    .rdata_o (walk_rdata)
  );

  // Remainder step of the walker pick and the hop target of a listed walker.
  always_comb begin
    trial   = {rem_q, pick_q[kds_pkg::PICK_W-1]};
    hr      = walk_rdata[2*CW-1:CW];
    hc      = walk_rdata[CW-1:0];
    hnr     = hr;
    hnc     = hc;
    hop_ok  = 1'b1;
    case (kds_pkg::dir_e'(dir_q))
      kds_pkg::DIR_ROW_DN: begin
        if (hr == '0) hop_ok = 1'b0;
        else hnr = hr - CW'(1);
      end
      kds_pkg::DIR_COL_DN: begin
        if (hc == '0) hop_ok = 1'b0;
        else hnc = hc - CW'(1);
      end
      kds_pkg::DIR_COL_UP: begin
        if (hc == SIDE_M1) hop_ok = 1'b0;
        else hnc = hc + CW'(1);
      end
      default: begin
        if (hr == SIDE_M1) hop_ok = 1'b0;
        else hnr = hr + CW'(1);
      end
    endcase
    key_hit = hv_q && (walk_rdata == key_q);
    n_m1    = n_q - WCW'(1);
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    n_d       = n_q;
    dsh_d     = dsh_q;
    ksh_d     = ksh_q;
    row_d     = row_q;
    col_d     = col_q;
    pick_d    = pick_q;
    dir_d     = dir_q;
    prod_d    = prod_q;
    rdep_d    = rdep_q;
    tsh_d     = tsh_q;
    rsh_d     = rsh_q;
    lacc_d    = lacc_q;
    racc_d    = racc_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    wr_d      = wr_q;
    wc_d      = wc_q;
    nr_d      = nr_q;
    nc_d      = nc_q;
    key_d     = key_q;
    ret_src_d = ret_src_q;
    k_d       = k_q;
    chk_d     = chk_q;
    j_d       = j_q;
    hv_d      = hv_q;
    res_d     = res_q;

    site_we    = 1'b0;
    site_waddr = site_addr(row_q, col_q);
    site_wdata = '0;
    site_raddr = site_addr(row_q, col_q);
    walk_we    = 1'b0;
    walk_waddr = n_q[WAW-1:0];
    walk_wdata = {row_q, col_q};
    walk_raddr = k_q[WAW-1:0];

    unique case (state_q)
      S_CLEAR: begin
        site_we    = 1'b1;
        site_waddr = clr_q;
        clr_d      = clr_q + SAW'(1);
        if (clr_q == CLR_END) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          dsh_d  = item_i.draw;
          ksh_d  = kds_pkg::DRAW_SCALE;
          row_d  = side_mod(item_i.site_row);
          col_d  = side_mod(item_i.site_col);
          pick_d = item_i.pick_raw;
          dir_d  = item_i.hop_dir;
          res_d  = '0;
          state_d = S_MUL0;
        end
      end

      // Rate products: walker diffusion total and SIDE^2 times deposition rate.
      S_MUL0: begin
        prod_d  = NDW'(n_q) * NDW'(diff_q);
        rdep_d  = RDW'(dep_q) * RDW'(SITES);
        state_d = S_MUL1;
      end

      S_MUL1: begin
        tsh_d   = PW'(TW'(rdep_q) + TW'(prod_q));
        rsh_d   = PW'(rdep_q);
        lacc_d  = '0;
        racc_d  = '0;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_LOOP;
      end

      // Shift-add products of the test and one remainder bit per cycle.
      S_LOOP: begin
        if (dsh_q[0]) lacc_d = lacc_q + tsh_q;
        if (ksh_q[0]) racc_d = racc_q + rsh_q;
        tsh_d  = tsh_q << 1;
        rsh_d  = rsh_q << 1;
        dsh_d  = dsh_q >> 1;
        ksh_d  = ksh_q >> 1;
        pick_d = pick_q << 1;
        if (trial >= {1'b0, n_q}) rem_d = WCW'(trial - {1'b0, n_q});
        else rem_d = WCW'(trial);
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_END) state_d = S_DEC;
      end

      S_DEC: begin
        if (lacc_q < racc_q) begin
          res_d.action = kds_pkg::ACT_DEPOSIT;
          state_d      = S_DRD;
        end else begin
          res_d.action = kds_pkg::ACT_DIFFUSE;
          walk_raddr   = rem_q[WAW-1:0];
          if (n_q == '0) begin
            res_d.status = kds_pkg::ST_EMPTY;
            state_d      = S_OUT;
          end else begin
            state_d = S_WRD;
          end
        end
      end

      // Deposition: site count arrives.
      S_DRD: begin
        if (site_rdata == 8'd0 && n_q >= CAP_N) begin
          res_d.status = kds_pkg::ST_FULL;
          state_d      = S_OUT;
        end else begin
          site_we       = 1'b1;
          site_wdata    = sat_inc(site_rdata);
          res_d.to_row  = 8'(row_q);
          res_d.to_col  = 8'(col_q);
          if (site_rdata == 8'd0) begin
            walk_we      = 1'b1;
            n_d          = n_q + WCW'(1);
            res_d.status = kds_pkg::ST_NEW;
            state_d      = S_OUT;
          end else begin
            res_d.status = kds_pkg::ST_OCCUPIED;
            key_d        = {row_q, col_q};
            ret_src_d    = 1'b0;
            k_d          = '0;
            hv_d         = 1'b0;
            state_d      = S_SRCH;
          end
        end
      end

      // Diffusion: picked walker arrives; read the hop target.
      S_WRD: begin
        wr_d       = hr;
        wc_d       = hc;
        nr_d       = hnr;
        nc_d       = hnc;
        site_raddr = site_addr(hnr, hnc);
        if (!hop_ok) begin
          res_d.status = kds_pkg::ST_BLOCKED;
          state_d      = S_OUT;
        end else begin
          state_d = S_TRD;
        end
      end

      S_TRD: begin
        if (site_rdata == 8'd0 && n_q >= CAP_N) begin
          res_d.status = kds_pkg::ST_FULL;
          state_d      = S_OUT;
        end else begin
          site_we         = 1'b1;
          site_waddr      = site_addr(nr_q, nc_q);
          site_wdata      = sat_inc(site_rdata);
          res_d.status    = kds_pkg::ST_HOPPED;
          res_d.to_row    = 8'(nr_q);
          res_d.to_col    = 8'(nc_q);
          res_d.from_row  = 8'(wr_q);
          res_d.from_col  = 8'(wc_q);
          if (site_rdata == 8'd0) begin
            walk_we    = 1'b1;
            walk_wdata = {nr_q, nc_q};
            n_d        = n_q + WCW'(1);
            state_d    = S_SRC;
          end else if (site_rdata == 8'd1) begin
            key_d     = {nr_q, nc_q};
            ret_src_d = 1'b1;
            k_d       = '0;
            hv_d      = 1'b0;
            state_d   = S_SRCH;
          end else begin
            state_d = S_SRC;
          end
        end
      end

      S_SRC: begin
        site_raddr = site_addr(wr_q, wc_q);
        state_d    = S_SRD;
      end

      // Source site loses its atom, then the walker leaves the list.
      S_SRD: begin
        site_waddr = site_addr(wr_q, wc_q);
        site_wdata = site_rdata - 8'd1;
        site_we    = (site_rdata != 8'd0);
        key_d      = {wr_q, wc_q};
        ret_src_d  = 1'b0;
        k_d        = '0;
        hv_d       = 1'b0;
        state_d    = S_SRCH;
      end

      // List search, one entry compared per cycle from entry 0.
      S_SRCH: begin
        if (key_hit) begin
          j_d        = chk_q;
          walk_raddr = n_m1[WAW-1:0];
          state_d    = S_MOVE;
        end else if (k_q < n_q) begin
          walk_raddr = k_q[WAW-1:0];
          chk_d      = k_q[WAW-1:0];
          k_d        = k_q + WCW'(1);
          hv_d       = 1'b1;
        end else begin
          state_d = ret_src_q ? S_SRC : S_OUT;
        end
      end

      // Last entry fills the hole.
      S_MOVE: begin
        walk_we    = 1'b1;
        walk_waddr = j_q;
        walk_wdata = walk_rdata;
        n_d        = n_m1;
        state_d    = ret_src_q ? S_SRC : S_OUT;
      end

      S_OUT: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      n_q     <= '0;
      dep_q   <= kds_pkg::RATE_ONE;
      diff_q  <= kds_pkg::RATE_ONE;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      n_q     <= n_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          kds_pkg::REG_DEP_RATE:  dep_q  <= cfg_wdata_i;
          kds_pkg::REG_DIFF_RATE: diff_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    dsh_q     <= dsh_d;
    ksh_q     <= ksh_d;
    row_q     <= row_d;
    col_q     <= col_d;
    pick_q    <= pick_d;
    dir_q     <= dir_d;
    prod_q    <= prod_d;
    rdep_q    <= rdep_d;
    tsh_q     <= tsh_d;
    rsh_q     <= rsh_d;
    lacc_q    <= lacc_d;
    racc_q    <= racc_d;
    cnt_q     <= cnt_d;
    rem_q     <= rem_d;
    wr_q      <= wr_d;
    wc_q      <= wc_d;
    nr_q      <= nr_d;
    nc_q      <= nc_d;
    key_q     <= key_d;
    ret_src_q <= ret_src_d;
    k_q       <= k_d;
    chk_q     <= chk_d;
    j_q       <= j_d;
    hv_q      <= hv_d;
    res_q     <= res_d;
  end

  // Outputs.
  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);

  always_comb begin
    result_o              = res_q;
    result_o.walker_count = kds_pkg::COUNT_W'(n_q);
  end

  // Checks.
  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o)) else $error("accepted item not in progress");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("core not idle after result");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CAP_N) else $error("walker count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_q.status == kds_pkg::ST_FULL) |-> (n_q == CAP_N))
    else $error("list full reported below capacity");

endmodule
